// ----- rtl/chc_pkg.sv -----
package chc_pkg;

  // Pipeline stages, input register first, result register last.
  localparam int NumStages = 8;
  localparam int StgIn     = 0;
  localparam int StgWiden  = 1;
  localparam int StgEst    = 2;
  localparam int StgRem    = 3;
  localparam int StgFix    = 4;
  localparam int StgSel    = 5;
  localparam int StgMul    = 6;
  localparam int StgOut    = 7;

  localparam int CoordW   = 32;
  localparam int CellW    = 16;
  localparam int WideFrac = 16;

  // Column path: box offset, quotient and remainder widths (Q.16 map units).
  localparam int CxW     = 45;
  localparam int EstLsb  = 22;
  localparam int QxW     = 20;
  localparam int RemW    = 26;
  localparam int EdgeW   = 23;
  localparam int ColW    = QxW + 2;

  // Row path widths.
  localparam int YqW     = 23;
  localparam int YrW     = 10;
  localparam int YcW     = 24;
  localparam int YRemW   = 25;
  localparam int RowSumW = YcW + 1;

  localparam int ProdW   = 49;

  localparam logic [EdgeW-1:0] AlphaQ  = 23'd6101253;
  localparam logic [RemW-1:0]  Alpha2Q = 26'd12202506;
  localparam logic [RemW-1:0]  Alpha3Q = 26'd18303759;
  localparam logic [RemW-1:0]  Alpha5Q = 26'd30506265;
  localparam logic [RemW-1:0]  BoxQ    = 26'd36607518;
  localparam logic [YRemW-1:0] FullYQ  = 25'd21135360;
  localparam logic [YRemW-1:0] HalfYQ  = 25'd10567680;

  // Row divisor in input units after dropping FRAC_BITS-1 bits: 322.5 * 2 = 645.
  localparam logic [YrW-1:0]    RowDiv     = 10'd645;
  localparam logic [CoordW-1:0] RowBias    = 32'd1352663040;  // 645 * 2^21
  localparam logic [YcW-1:0]    RowBiasQuo = 24'd2097152;     // 2^21

  // Reciprocals for estimate-and-correct division by constants.
  localparam logic [28:0] BoxRecip = 29'((64'd1 << 54) / 64'd36607518);
  localparam logic [31:0] RowRecip = 32'((64'd1 << 41) / 64'd645);

  localparam int CellMaxI = 32767;
  localparam int CellMinI = -32768;

  typedef enum logic [1:0] {
    BandLeft,
    BandMid,
    BandRise,
    BandFall
  } band_e;

  typedef struct packed {
    logic            left;
    logic            neg;
    logic [QxW-1:0]  quo;
    logic [RemW-1:0] rem;
  } box_t;

  typedef struct packed {
    logic signed [YcW-1:0] idx;
    logic [YRemW-1:0]      frac;
  } row_t;

endpackage

// ----- rtl/cartesian_to_hex_cell.sv -----
// Throughput: one transaction per cycle while stall_i is low; the eight-register
// pipeline (input, six working stages, result) advances in every stage whose
// downstream has room. Reset (rst_ni low, asynchronous) clears every stage
// valid bit; data registers are not reset and the block is ready again in the
// first cycle after release.
module cartesian_to_hex_cell import chc_pkg::*; #(
  parameter int FRAC_BITS = 6
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic signed [CoordW-1:0] point_x_i,
  input  logic signed [CoordW-1:0] point_y_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic signed [CellW-1:0]  cell_column_o,
  output logic signed [CellW-1:0]  cell_row_o
);

  // Stage k advances when it is empty or when stage k+1 advances; the result
  // stage advances when it is empty or the consumer takes the transaction.
  // This lets bubbles collapse, so new points keep entering while a finished
  // result is held for a stalled consumer.
  logic [NumStages-1:0] vld_q, vld_d, adv, vld_prev;

  assign adv[StgOut]   = !vld_q[StgOut] || !stall_i;
  assign vld_prev      = {vld_q[NumStages-2:0], valid_i};

  for (genvar g = 0; g < NumStages - 1; g++) begin : g_adv
    assign adv[g] = !vld_q[g] || adv[g+1];
  end

  // Load the upstream valid bit on advance, hold otherwise.
  for (genvar g = 0; g < NumStages; g++) begin : g_vld
    assign vld_d[g] = adv[g] ? vld_prev[g] : vld_q[g];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign stall_o = !adv[StgIn];
  assign valid_o = vld_q[StgOut];

  // Input register: capture the point on every accepted transaction.
  logic signed [CoordW-1:0] point_x_q, point_y_q;

  always_ff @(posedge clk_i) begin
    if (adv[StgIn]) begin
      point_x_q <= point_x_i;
      point_y_q <= point_y_i;
    end
  end

  // Column path: widen x to Q.16, drop alpha, split into box index and
  // in-box offset by reciprocal estimate plus one correction step.
  box_t box;

  chc_box_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_box_div (
    .clk_i(clk_i),
    .adv_i(adv),
    .x_i  (point_x_q),
    .box_o(box)
  );

  // Row path: floor division of y by the hex height, with the remainder
  // rebuilt in Q.16 for the edge tests.
  row_t row;

  chc_row_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_row_div (
    .clk_i(clk_i),
    .adv_i(adv),
    .y_i  (point_y_q),
    .row_o(row)
  );

  // Band decision, sloped edge products, final cell step and saturation;
  // the result register sits inside.
  chc_edge u_edge (
    .clk_i        (clk_i),
    .adv_i        (adv),
    .box_i        (box),
    .row_i        (row),
    .cell_column_o(cell_column_o),
    .cell_row_o   (cell_row_o)
  );

endmodule

// ----- rtl/chc_box_div.sv -----
module chc_box_div import chc_pkg::*; #(
  parameter int FRAC_BITS = 6
) (
  input  logic                     clk_i,
  input  logic [NumStages-1:0]     adv_i,
  input  logic signed [CoordW-1:0] x_i,
  output box_t                     box_o
);

  localparam logic signed [47:0] AlphaS = 48'(AlphaQ);

  logic signed [47:0] cx;
  logic signed [47:0] cx_off;

  assign cx     = 48'(x_i) <<< (WideFrac - FRAC_BITS);
  assign cx_off = cx - AlphaS;

  // Widen and offset
  logic           wid_left_q, wid_neg_q;
  logic [CxW-1:0] wid_cx_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgWiden]) begin
      wid_left_q <= cx < AlphaS;
      wid_neg_q  <= x_i[CoordW-1];
      wid_cx_q   <= cx_off[CxW-1:0];
    end
  end

  // Quotient estimate from the top bits, at most one low
  logic [51:0]    est_prod;
  logic           est_left_q, est_neg_q;
  logic [CxW-1:0] est_cx_q;
  logic [QxW-1:0] est_quo_q;

  assign est_prod = 52'(wid_cx_q[CxW-1:EstLsb]) * 52'(BoxRecip);

  always_ff @(posedge clk_i) begin
    if (adv_i[StgEst]) begin
      est_left_q <= wid_left_q;
      est_neg_q  <= wid_neg_q;
      est_cx_q   <= wid_cx_q;
      est_quo_q  <= est_prod[51:32];
    end
  end

  // Remainder against the estimate, below twice the box width
  logic [CxW:0]   quo_box;
  logic [CxW:0]   rem_wide;
  logic           rem_left_q, rem_neg_q;
  logic [QxW-1:0] rem_quo_q;
  logic [RemW:0]  rem_est_q;

  assign quo_box  = (CxW+1)'(est_quo_q) * (CxW+1)'(BoxQ);
  assign rem_wide = {1'b0, est_cx_q} - quo_box;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgRem]) begin
      rem_left_q <= est_left_q;
      rem_neg_q  <= est_neg_q;
      rem_quo_q  <= est_quo_q;
      rem_est_q  <= rem_wide[RemW:0];
    end
  end

  // Correct by one box
  box_t          box_d, box_q;
  logic          over;
  logic [RemW:0] rem_less;

  assign over     = rem_est_q >= {1'b0, BoxQ};
  assign rem_less = rem_est_q - {1'b0, BoxQ};

  always_comb begin
    box_d.left = rem_left_q;
    box_d.neg  = rem_neg_q;
    box_d.quo  = over ? rem_quo_q + QxW'(1) : rem_quo_q;
    box_d.rem  = over ? rem_less[RemW-1:0] : rem_est_q[RemW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgFix]) begin
      box_q <= box_d;
    end
  end

  assign box_o = box_q;

endmodule

// ----- rtl/chc_row_div.sv -----
module chc_row_div import chc_pkg::*; #(
  parameter int FRAC_BITS = 6
) (
  input  logic                     clk_i,
  input  logic [NumStages-1:0]     adv_i,
  input  logic signed [CoordW-1:0] y_i,
  output row_t                     row_o
);

  localparam int LowW = FRAC_BITS - 1;

  logic signed [CoordW-1:0] y_half;
  logic [CoordW:0]          biased;

  assign y_half = y_i >>> LowW;
  assign biased = (CoordW+1)'(y_half) + (CoordW+1)'(RowBias);

  // Bias to a nonnegative dividend
  logic [CoordW-1:0] wid_u_q;
  logic [LowW-1:0]   wid_low_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgWiden]) begin
      wid_u_q   <= biased[CoordW-1:0];
      wid_low_q <= y_i[LowW-1:0];
    end
  end

  // Quotient estimate
  logic [63:0]       est_prod;
  logic [CoordW-1:0] est_u_q;
  logic [LowW-1:0]   est_low_q;
  logic [YqW-1:0]    est_quo_q;

  assign est_prod = 64'(wid_u_q) * 64'(RowRecip);

  always_ff @(posedge clk_i) begin
    if (adv_i[StgEst]) begin
      est_u_q   <= wid_u_q;
      est_low_q <= wid_low_q;
      est_quo_q <= est_prod[63:41];
    end
  end

  // Remainder against the estimate
  logic [YqW+YrW-1:0] quo_div;
  logic [CoordW:0]    rem_wide;
  logic [LowW-1:0]    rem_low_q;
  logic [YqW-1:0]     rem_quo_q;
  logic [YrW:0]       rem_est_q;

  assign quo_div  = (YqW+YrW)'(est_quo_q) * (YqW+YrW)'(RowDiv);
  assign rem_wide = {1'b0, est_u_q} - quo_div;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgRem]) begin
      rem_low_q <= est_low_q;
      rem_quo_q <= est_quo_q;
      rem_est_q <= rem_wide[YrW:0];
    end
  end

  // Correct, remove the bias and rebuild the Q.16 remainder
  logic          over;
  logic [YrW:0]  rem_less;
  logic [YrW-1:0] rem_fix;
  logic [YqW-1:0] quo_fix;
  row_t          row_d, row_q;

  assign over     = rem_est_q >= {1'b0, RowDiv};
  assign rem_less = rem_est_q - {1'b0, RowDiv};
  assign rem_fix  = over ? rem_less[YrW-1:0] : rem_est_q[YrW-1:0];
  assign quo_fix  = over ? rem_quo_q + YqW'(1) : rem_quo_q;

  always_comb begin
    row_d.idx  = $signed(YcW'(quo_fix) - RowBiasQuo);
    row_d.frac = YRemW'({rem_fix, rem_low_q}) << (WideFrac - FRAC_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgFix]) begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

// ----- rtl/chc_edge.sv -----
module chc_edge import chc_pkg::*; (
  input  logic                    clk_i,
  input  logic [NumStages-1:0]    adv_i,
  input  box_t                    box_i,
  input  row_t                    row_i,
  output logic signed [CellW-1:0] cell_column_o,
  output logic signed [CellW-1:0] cell_row_o
);

  // Band select and sloped-test operands
  logic             hi;
  band_e            band_d;
  logic [EdgeW-1:0] run_d;
  logic [YRemW-1:0] rise_d;
  logic [RemW-1:0]  rem_a2, rem_a5, box_rem;

  assign hi      = row_i.frac >= HalfYQ;
  assign rem_a2  = box_i.rem - Alpha2Q;
  assign rem_a5  = box_i.rem - Alpha5Q;
  assign box_rem = BoxQ - box_i.rem;

  always_comb begin
    priority if (box_i.rem < Alpha2Q) begin
      band_d = BandLeft;
    end else if (box_i.rem >= Alpha3Q && box_i.rem < Alpha5Q) begin
      band_d = BandMid;
    end else if (box_i.rem < Alpha3Q) begin
      band_d = BandRise;
    end else begin
      band_d = BandFall;
    end
  end

  always_comb begin
    run_d  = '0;
    rise_d = '0;
    unique case (band_d)
      BandRise: begin
        run_d  = rem_a2[EdgeW-1:0];
        rise_d = hi ? FullYQ - row_i.frac : row_i.frac;
      end
      BandFall: begin
        if (hi) begin
          run_d  = rem_a5[EdgeW-1:0];
          rise_d = row_i.frac - HalfYQ;
        end else begin
          run_d  = box_rem[EdgeW-1:0];
          rise_d = row_i.frac;
        end
      end
      BandLeft, BandMid: begin
      end
    endcase
  end

  band_e                 sel_band_q;
  logic                  sel_hi_q, sel_left_q, sel_neg_q;
  logic [QxW-1:0]        sel_quo_q;
  logic signed [YcW-1:0] sel_idx_q;
  logic [EdgeW-1:0]      sel_run_q;
  logic [YRemW-1:0]      sel_rise_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgSel]) begin
      sel_band_q <= band_d;
      sel_hi_q   <= hi;
      sel_left_q <= box_i.left;
      sel_neg_q  <= box_i.neg;
      sel_quo_q  <= box_i.quo;
      sel_idx_q  <= row_i.idx;
      sel_run_q  <= run_d;
      sel_rise_q <= rise_d;
    end
  end

  // Cross products: 2*alpha*rise against run*full_y
  band_e                 mul_band_q;
  logic                  mul_hi_q, mul_left_q, mul_neg_q;
  logic [QxW-1:0]        mul_quo_q;
  logic signed [YcW-1:0] mul_idx_q;
  logic [ProdW-1:0]      mul_lhs_q, mul_rhs_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[StgMul]) begin
      mul_band_q <= sel_band_q;
      mul_hi_q   <= sel_hi_q;
      mul_left_q <= sel_left_q;
      mul_neg_q  <= sel_neg_q;
      mul_quo_q  <= sel_quo_q;
      mul_idx_q  <= sel_idx_q;
      mul_lhs_q  <= ProdW'(sel_rise_q) * ProdW'(Alpha2Q);
      mul_rhs_q  <= ProdW'(sel_run_q) * ProdW'(FullYQ);
    end
  end

  // Cell step, then saturate
  logic                      le;
  logic [1:0]                col_inc;
  logic                      row_inc;
  logic [ColW-1:0]           col_sum;
  logic signed [RowSumW-1:0] row_sum;
  logic signed [CellW-1:0]   col_d, row_d;
  logic signed [CellW-1:0]   cell_column_q, cell_row_q;

  assign le = mul_lhs_q <= mul_rhs_q;

  always_comb begin
    col_inc = 2'd0;
    row_inc = 1'b0;
    unique case (mul_band_q)
      BandLeft: begin
      end
      BandMid: begin
        col_inc = 2'd1;
        row_inc = mul_hi_q;
      end
      BandRise: begin
        if (le) begin
          col_inc = 2'd1;
          row_inc = mul_hi_q;
        end
      end
      BandFall: begin
        if (mul_hi_q && !le) begin
          col_inc = 2'd1;
          row_inc = 1'b1;
        end else if (mul_hi_q || !le) begin
          col_inc = 2'd2;
        end else begin
          col_inc = 2'd1;
        end
      end
    endcase
    if (mul_left_q) begin
      col_inc = 2'd0;
      row_inc = 1'b0;
    end
  end

  assign col_sum = {1'b0, mul_quo_q, 1'b0} + ColW'(col_inc);
  assign row_sum = RowSumW'(mul_idx_q) + RowSumW'({1'b0, row_inc});

  always_comb begin
    if (mul_left_q) begin
      col_d = mul_neg_q ? '1 : '0;
    end else if (col_sum > ColW'(CellMaxI)) begin
      col_d = CellW'(CellMaxI);
    end else begin
      col_d = $signed(col_sum[CellW-1:0]);
    end

    if (row_sum > RowSumW'(CellMaxI)) begin
      row_d = CellW'(CellMaxI);
    end else if (row_sum < RowSumW'(CellMinI)) begin
      row_d = CellW'(CellMinI);
    end else begin
      row_d = row_sum[CellW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i[StgOut]) begin
      cell_column_q <= col_d;
      cell_row_q    <= row_d;
    end
  end

  assign cell_column_o = cell_column_q;
  assign cell_row_o    = cell_row_q;

endmodule

// ----- tb/sv/cartesian_to_hex_cell_test.sv -----
module cartesian_to_hex_cell_test;
  timeunit 1ns;
  timeprecision 1ps;

  import chc_pkg::*;

  localparam int FracBits   = 6;
  localparam int NumRandom  = 1900;
  localparam int IdlePct    = 14;
  localparam int StallLimit = 2000;
  localparam int DrainWait  = 20;

  // FracBits = 6: alpha, box in Q.16 (widen 2^10); rows in input units.
  localparam longint AlphaWide = 6101253;
  localparam longint BoxWide   = 36607518;
  localparam int     RowIn     = 20640;
  localparam int     HalfRowIn = 10320;

  typedef struct packed {
    logic signed [CellW-1:0] column;
    logic signed [CellW-1:0] row;
  } cell_t;

  // Scoreboard: predicts the hex cell of every accepted point and compares
  // the results in order.
  class cell_scoreboard #(int FRAC = 6);
    localparam longint Alpha = 6101253;
    localparam longint FullY = 21135360;
    localparam longint HalfY = 10567680;

    cell_t pending[$];
    int    errors;

    function logic signed [CellW-1:0] clamp_cell(longint v);
      if (v > CellMaxI) v = CellMaxI;
      if (v < CellMinI) v = CellMinI;
      return v[CellW-1:0];
    endfunction

    function cell_t predict_cell(logic signed [CoordW-1:0] px,
                                 logic signed [CoordW-1:0] py);
      longint cx, cy, yc, y, xc, x, box, run;
      cell_t  c;
      cx  = longint'(px) * (longint'(1) << (WideFrac - FRAC));
      cy  = longint'(py) * (longint'(1) << (WideFrac - FRAC));
      box = 6 * Alpha;
      // Floor division for the row, truncation for the box.
      if (cy >= 0) yc = cy / FullY;
      else yc = -((-cy + FullY - 1) / FullY);
      y = cy - yc * FullY;
      if (cx < Alpha) begin
        c.column = (cx < 0) ? -16'sd1 : 16'sd0;
        c.row    = clamp_cell(yc);
        return c;
      end
      cx = cx - Alpha;
      xc = cx / box;
      x  = cx - xc * box;
      xc = xc * 2;
      if (x < 2 * Alpha) begin
        // left column of the box, nothing to adjust
      end else if (x >= 3 * Alpha && x < 5 * Alpha) begin
        xc++;
        if (y >= HalfY) yc++;
      end else if (x < 3 * Alpha) begin
        run = (x - 2 * Alpha) * FullY;
        if (y >= HalfY) begin
          if (2 * Alpha * (FullY - y) <= run) begin
            xc++;
            yc++;
          end
        end else if (2 * Alpha * y <= run) begin
          xc++;
        end
      end else if (y >= HalfY) begin
        xc++;
        if (2 * Alpha * (y - HalfY) > (x - 5 * Alpha) * FullY) yc++;
        else xc++;
      end else begin
        xc++;
        if (2 * Alpha * y > (box - x) * FullY) xc++;
      end
      c.column = clamp_cell(xc);
      c.row    = clamp_cell(yc);
      return c;
    endfunction

    function void note_point(logic signed [CoordW-1:0] px, logic signed [CoordW-1:0] py);
      pending.push_back(predict_cell(px, py));
    endfunction

    function void check_cell(logic signed [CellW-1:0] col, logic signed [CellW-1:0] row);
      cell_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result column %0d row %0d", $time, col, row);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (col !== want.column) begin
        $display("%0t: cell_column expected %0d, got %0d", $time, want.column, col);
        errors++;
      end
      if (row !== want.row) begin
        $display("%0t: cell_row expected %0d, got %0d", $time, want.row, row);
        errors++;
      end
    endfunction
  endclass

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     valid_i       = 1'b0;
  logic signed [CoordW-1:0] point_x_i     = '0;
  logic signed [CoordW-1:0] point_y_i     = '0;
  logic                     stall_i       = 1'b0;
  logic                     stall_o;
  logic                     valid_o;
  logic signed [CellW-1:0]  cell_column_o;
  logic signed [CellW-1:0]  cell_row_o;

  // Set while both sides run without idling, to keep the pipe full.
  bit steady = 1'b0;

  cell_scoreboard #(FracBits) board = new;

  cartesian_to_hex_cell #(
    .FRAC_BITS(FracBits)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .cell_column_o(cell_column_o),
    .cell_row_o   (cell_row_o)
  );

  always #10 clk_i = ~clk_i;

  // Offer one point and hold it until the block takes the transaction.
  // Values sampled right at the edge are the ones that decided it.
  task automatic send_point(input logic signed [CoordW-1:0] x,
                            input logic signed [CoordW-1:0] y);
    while (!steady && $urandom_range(0, 99) < IdlePct) begin
      valid_i <= 1'b0;
      @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    do @(posedge clk_i); while (stall_o);
    board.note_point(x, y);
  endtask

  // Mix full-range noise, points on the mapped area, and points packed
  // around band boundaries and row halves where the edge tests decide.
  task automatic send_random_point();
    int     pick, k, b;
    longint xw;
    logic signed [CoordW-1:0] x, y;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      x = $urandom();
      y = $urandom();
    end else if (pick < 60) begin
      x = int'($urandom_range(0, 800000)) - 10000;
      y = int'($urandom_range(0, 800000)) - 400000;
    end else begin
      k  = $urandom_range(0, 20);
      b  = $urandom_range(0, 6);
      xw = AlphaWide * (1 + b) + BoxWide * k;
      x  = int'(xw / 1024) + int'($urandom_range(0, 80)) - 40;
      y  = (int'($urandom_range(0, 40)) - 20) * RowIn;
      case ($urandom_range(0, 2))
        0: y = y + int'($urandom_range(0, 6)) - 3;
        1: y = y + HalfRowIn + int'($urandom_range(0, 6)) - 3;
        default: y = y + int'($urandom_range(0, RowIn - 1));
      endcase
    end
    send_point(x, y);
  endtask

  // Drain the results; stall at random outside the steady stretch.
  initial begin : result_sink
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (valid_o && !stall_i) board.check_cell(cell_column_o, cell_row_o);
      stall_i <= !steady && ($urandom_range(0, 99) < IdlePct);
    end
  end

  // Watchdog: drop the run when no transaction moves for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet = 0;
      else quiet++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin : point_source
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Extremes of both fields and sign corners.
    send_point(32'sd0, 32'sd0);
    send_point(-32'sd1, -32'sd1);
    send_point(32'sh7fffffff, 32'sh7fffffff);
    send_point(32'sh80000000, 32'sh80000000);
    send_point(32'sh7fffffff, 32'sh80000000);
    send_point(32'sh80000000, 32'sh7fffffff);
    // Left of alpha and just past it.
    send_point(32'sd5958, 32'sd10000);
    send_point(32'sd5959, 32'sd10000);
    send_point(-32'sd5000, -32'sd30000);
    // Row boundaries, exact and one below.
    send_point(-32'sd1, RowIn);
    send_point(32'sd100, RowIn - 1);
    send_point(32'sd100, -RowIn);
    send_point(32'sd100, -RowIn - 1);
    // Each band of the first box, both halves of the row and the half line.
    send_point(32'sd8959, 32'sd5000);
    send_point(32'sd19875, 32'sd1000);
    send_point(32'sd19875, 32'sd20000);
    send_point(32'sd19875, HalfRowIn);
    send_point(32'sd26833, HalfRowIn - 1);
    send_point(32'sd26833, HalfRowIn);
    send_point(32'sd37749, 32'sd5000);
    send_point(32'sd37749, 32'sd15000);
    send_point(32'sd37749, HalfRowIn);
    send_point(32'sd41809, 32'sd300);

    for (int n = 0; n < NumRandom; n++) begin
      steady <= (n >= 900 && n < 1200);
      send_random_point();
    end
    steady  <= 1'b0;
    valid_i <= 1'b0;

    // Wait out the pipe, then keep watching for stray results.
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    board.errors += board.pending.size();

    if (board.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/chc_pkg.sv
rtl/chc_box_div.sv
rtl/chc_row_div.sv
rtl/chc_edge.sv
rtl/cartesian_to_hex_cell.sv
tb/sv/cartesian_to_hex_cell_test.sv
